/* design/dtq_pkg.sv */
package dtq_pkg;

	// queue geometry
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// field widths
	localparam int TAG_W   = 32;
	localparam int DUR_W   = 16;
	localparam int LEN_W   = 7;
	localparam int ENTRY_W = TAG_W + DUR_W;

	// width wide enough for both the fill count and the limit register
	localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int LEN_MAX = (1 << LEN_W) - 1;

	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(64);

	// item kinds
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_ARRIVAL = 1'b1;

	typedef enum logic [0:0] {
		ST_RUN,
		ST_DEQ
	} dtq_state_t;

	typedef logic [ADDR_W-1:0] dtq_addr_t;
	typedef logic [CNT_W-1:0]  dtq_cnt_t;

	function automatic dtq_addr_t next_addr(input dtq_addr_t a);
		if (32'(a) == DEPTH - 1) begin
			return '0;
		end
		return a + ADDR_W'(1);
	endfunction

	// reported length, saturating when the queue is deeper than the field
	function automatic logic [LEN_W-1:0] sat_len(input dtq_cnt_t c);
		if (CMP_W'(c) > CMP_W'(LEN_MAX)) begin
			return LEN_W'(LEN_MAX);
		end
		return LEN_W'(c);
	endfunction

endpackage

/* design/dtq_if.sv */
interface dtq_item_if import dtq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [TAG_W-1:0] packet_tag;
	logic [DUR_W-1:0] duration;

	modport source (output valid, output func, output packet_tag, output duration,
		input ready);
	modport sink (input valid, input func, input packet_tag, input duration,
		output ready);
endinterface

interface dtq_result_if import dtq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             sent;
	logic [TAG_W-1:0] sent_tag;
	logic [DUR_W-1:0] sent_duration;
	logic             dropped;
	logic [LEN_W-1:0] queue_length;

	modport source (output valid, output sent, output sent_tag, output sent_duration,
		output dropped, output queue_length, input ready);
	modport sink (input valid, input sent, input sent_tag, input sent_duration,
		input dropped, input queue_length, output ready);
endinterface

/* design/dtq_ram.sv */
module dtq_ram #(
	parameter int Width = 48,
	parameter int Depth = 64,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/drop_tail_queue_server.sv */
// channel   dir  beat payload                                      handshake
// item      in   func, packet_tag, duration                        valid/ready
// result    out  sent, sent_tag, sent_duration, dropped, len       valid/ready
// cfg       in   cfg_wdata -> buffer_limit                         cfg_we, no wait
//
// one item per cycle while item.ready is high; a tick that ends a service with packets
// waiting is answered from ST_DEQ, which waits on the registered read of the queue ram
// one result register sits on the output; a new item is taken while the
// previous result is being taken in the same cycle
// item.ready drops while the result register is full and not taken, and
// during the queue ram read cycle
// reset clears pointers, count, server state and sets the limit to 64;
// queue ram contents are not cleared (an entry is only read after written)
module drop_tail_queue_server import dtq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	dtq_item_if.sink        item,
	dtq_result_if.source    result,
	input  logic            cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata
);

	// control state
	dtq_state_t        state_q, state_d;
	dtq_addr_t         head_q, head_d;
	dtq_addr_t         tail_q, tail_d;
	dtq_cnt_t          count_q, count_d;
	logic              busy_q, busy_d;
	logic [DUR_W-1:0]  ticks_q, ticks_d;
	logic [LEN_W-1:0]  limit_q;

	// result register
	logic              res_valid_q;
	logic              res_load;
	logic              res_sent_q, res_sent_d;
	logic [TAG_W-1:0]  res_tag_q, res_tag_d;
	logic [DUR_W-1:0]  res_dur_q, res_dur_d;
	logic              res_drop_q, res_drop_d;
	logic [LEN_W-1:0]  res_len_q, res_len_d;

	// queue ram
	logic              ram_we;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [TAG_W-1:0]  head_tag;
	logic [DUR_W-1:0]  head_dur;

	logic              item_fire;
	logic              res_take;
	logic [CMP_W-1:0]  limit_ext;
	logic [CMP_W-1:0]  limit_eff;
	logic              full;

	assign res_take   = result.valid & result.ready;
	// accept when running and the result slot is free or emptying now
	assign item.ready = (state_q == ST_RUN) & (~res_valid_q | result.ready);
	assign item_fire  = item.valid & item.ready;

	// effective limit is min(buffer_limit, DEPTH)
	assign limit_ext = CMP_W'(limit_q);
	assign limit_eff = (limit_ext < CMP_W'(DEPTH)) ? limit_ext : CMP_W'(DEPTH);
	assign full      = CMP_W'(count_q) >= limit_eff;

	assign head_tag = ram_rdata[ENTRY_W-1:DUR_W];
	assign head_dur = ram_rdata[DUR_W-1:0];

	dtq_ram #(
		.Width (ENTRY_W),
		.Depth (DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({item.packet_tag, item.duration}),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// next state and datapath control
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		busy_d     = busy_q;
		ticks_d    = ticks_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		res_load   = 1'b0;
		res_sent_d = 1'b0;
		res_tag_d  = '0;
		res_dur_d  = '0;
		res_drop_d = 1'b0;
		res_len_d  = sat_len(count_q);

		unique case (state_q)
			ST_RUN: begin
				if (item_fire) begin
					res_load = 1'b1;
					if (item.func == FUNC_ARRIVAL) begin
						if (full) begin
							// tail drop, also with an idle server
							res_drop_d = 1'b1;
						end else if (!busy_q) begin
							// straight into service, never waits
							busy_d     = 1'b1;
							ticks_d    = (item.duration == '0) ? DUR_W'(1) : item.duration;
							res_sent_d = 1'b1;
							res_tag_d  = item.packet_tag;
							res_dur_d  = item.duration;
						end else begin
							ram_we    = 1'b1;
							tail_d    = next_addr(tail_q);
							count_d   = count_q + CNT_W'(1);
							res_len_d = sat_len(count_q + CNT_W'(1));
						end
					end else if (busy_q) begin
						if (ticks_q > DUR_W'(1)) begin
							ticks_d = ticks_q - DUR_W'(1);
						end else if (count_q != '0) begin
							// service ends, fetch head; ST_DEQ loads the result
							res_load = 1'b0;
							ram_re   = 1'b1;
							state_d  = ST_DEQ;
						end else begin
							busy_d  = 1'b0;
							ticks_d = '0;
						end
					end
				end
			end
			ST_DEQ: begin
				// head entry is on the ram output
				res_load   = 1'b1;
				head_d     = next_addr(head_q);
				count_d    = count_q - CNT_W'(1);
				ticks_d    = (head_dur == '0) ? DUR_W'(1) : head_dur;
				res_sent_d = 1'b1;
				res_tag_d  = head_tag;
				res_dur_d  = head_dur;
				res_len_d  = sat_len(count_q - CNT_W'(1));
				state_d    = ST_RUN;
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			ticks_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			busy_q  <= busy_d;
			ticks_q <= ticks_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sent_q <= res_sent_d;
			res_tag_q  <= res_tag_d;
			res_dur_q  <= res_dur_d;
			res_drop_q <= res_drop_d;
			res_len_q  <= res_len_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.sent          = res_sent_q;
	assign result.sent_tag      = res_tag_q;
	assign result.sent_duration = res_dur_q;
	assign result.dropped       = res_drop_q;
	assign result.queue_length  = res_len_q;

	// fill count never passes the ram depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("queue count above depth");

	// packets only wait behind a busy server
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (count_q == '0))
		else $error("packets waiting while server idle");

	// a busy server always has a nonzero countdown
	a_busy_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (ticks_q != '0))
		else $error("busy server with zero countdown");

	// the read cycle always has a head entry and yields a sent beat
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEQ) |-> (count_q != '0) && busy_q)
		else $error("dequeue from empty queue");

	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEQ) |=> res_valid_q && res_sent_q && (state_q == ST_RUN))
		else $error("dequeue did not produce a sent beat");

endmodule

/* bench/drop_tail_queue_server_tb.sv */
`timescale 1ns / 100ps

module drop_tail_queue_server_tb;
	import dtq_pkg::*;

	// generous cycle ceiling, many times the slowest legal run
	localparam int CYCLE_LIMIT = 300000;

	// one result beat as the block reports it
	typedef struct packed {
		logic             sent;
		logic [TAG_W-1:0] tag;
		logic [DUR_W-1:0] dur;
		logic             dropped;
		logic [LEN_W-1:0] len;
	} outcome_t;

	// one packet waiting for the server
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [DUR_W-1:0] dur;
	} packet_t;

	// mirror of the queue and server, plus the store of outcomes not yet seen
	class queue_server_scoreboard;
		packet_t          waiting[$];
		outcome_t         expected_outcomes[$];
		bit               busy;
		int unsigned      ticks_left;
		logic [LEN_W-1:0] limit;
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      n_items;
		int unsigned      n_sent;
		int unsigned      n_dropped;

		function new();
			busy       = 1'b0;
			ticks_left = 0;
			limit      = LIMIT_RESET;
			errors     = 0;
			checked    = 0;
			n_items    = 0;
			n_sent     = 0;
			n_dropped  = 0;
		endfunction

		function void set_limit(input logic [LEN_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction

		function void flag(input string msg);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] mismatch: %s", $time, msg);
			end
		endfunction

		// packet enters service; a zero duration still holds the server one tick
		function outcome_t start_service(input logic [TAG_W-1:0] t, input logic [DUR_W-1:0] d);
			outcome_t o;
			o          = '0;
			busy       = 1'b1;
			ticks_left = (d == '0) ? 1 : int'(d);
			o.sent     = 1'b1;
			o.tag      = t;
			o.dur      = d;
			n_sent++;
			return o;
		endfunction

		// predict the outcome of one accepted item beat
		function void note_item(input logic f, input logic [TAG_W-1:0] t,
			input logic [DUR_W-1:0] d);
			outcome_t o;
			packet_t  p;
			int       eff;
			o   = '0;
			eff = (int'(limit) < DEPTH) ? int'(limit) : DEPTH;
			n_items++;
			if (f == FUNC_ARRIVAL) begin
				if (waiting.size() >= eff) begin
					o.dropped = 1'b1;
					n_dropped++;
				end else if (!busy) begin
					o = start_service(t, d);
				end else begin
					p.tag = t;
					p.dur = d;
					waiting.push_back(p);
				end
			end else if (busy) begin
				if (ticks_left > 1) begin
					ticks_left--;
				end else if (waiting.size() > 0) begin
					p = waiting.pop_front();
					o = start_service(p.tag, p.dur);
				end else begin
					busy       = 1'b0;
					ticks_left = 0;
				end
			end
			o.len = (waiting.size() > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(waiting.size());
			expected_outcomes.push_back(o);
		endfunction

		// compare one accepted result beat with the oldest prediction
		function void check_result(input outcome_t got);
			outcome_t exp;
			if (expected_outcomes.size() == 0) begin
				flag($sformatf("result beat with no item outstanding: sent=%0b tag=%h dur=%h drop=%0b len=%0d",
					got.sent, got.tag, got.dur, got.dropped, got.len));
				return;
			end
			exp = expected_outcomes.pop_front();
			checked++;
			if (got.sent !== exp.sent || got.tag !== exp.tag || got.dur !== exp.dur ||
				got.dropped !== exp.dropped || got.len !== exp.len) begin
				flag($sformatf("exp sent=%0b tag=%h dur=%h drop=%0b len=%0d, got sent=%0b tag=%h dur=%h drop=%0b len=%0d",
					exp.sent, exp.tag, exp.dur, exp.dropped, exp.len,
					got.sent, got.tag, got.dur, got.dropped, got.len));
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	// random idling on both sides, switched off for the closing phase
	bit          bursts_on = 1'b1;
	int unsigned cycles = 0;
	int unsigned n_writes = 0;

	queue_server_scoreboard sb = new();

	dtq_item_if   item_ch();
	dtq_result_if result_ch();

	drop_tail_queue_server DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outcomes still outstanding", cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// monitor: sample both channels on pre-edge values
	always @(posedge clk) begin
		outcome_t got;
		if (result_ch.valid && result_ch.ready) begin
			got.sent    = result_ch.sent;
			got.tag     = result_ch.sent_tag;
			got.dur     = result_ch.sent_duration;
			got.dropped = result_ch.dropped;
			got.len     = result_ch.queue_length;
			sb.check_result(got);
		end
		if (item_ch.valid && item_ch.ready) begin
			sb.note_item(item_ch.func, item_ch.packet_tag, item_ch.duration);
		end
	end

	// result side: ready with random stall bursts
	initial begin
		result_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (bursts_on && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// present one item beat and hold it until taken
	task automatic drive_item(input logic f, input logic [TAG_W-1:0] t, input logic [DUR_W-1:0] d);
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.func       <= f;
		item_ch.packet_tag <= t;
		item_ch.duration   <= d;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// stop sending and let every outstanding result drain
	// the first wait lets the monitor note the last accepted beat
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// limit register write, only issued while settled
	task automatic write_limit(input logic [LEN_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.set_limit(v);
		n_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random traffic under one limit setting
	// ticks carry junk payload that the block must ignore
	task automatic run_phase(input logic [LEN_W-1:0] lim, input int n, input int arrival_pct,
		input int dur_max, input bit full_range);
		logic [DUR_W-1:0] d;
		settle();
		write_limit(lim);
		for (int i = 0; i < n; i++) begin
			d = full_range ? DUR_W'($urandom) : DUR_W'($urandom_range(0, dur_max));
			if ($urandom_range(1, 100) <= arrival_pct) begin
				drive_item(FUNC_ARRIVAL, TAG_W'($urandom), d);
			end else begin
				drive_item(FUNC_TICK, TAG_W'($urandom), d);
			end
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.func       <= FUNC_TICK;
		item_ch.packet_tag <= '0;
		item_ch.duration   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset limit, tick while idle, idle arrival, zero duration
		drive_item(FUNC_TICK, '1, '1);
		drive_item(FUNC_ARRIVAL, '0, '0);
		drive_item(FUNC_ARRIVAL, '1, DUR_W'(2));
		drive_item(FUNC_ARRIVAL, TAG_W'(32'ha5a5_a5a5), '0);
		// zero-duration service ends on the first tick, head goes out
		drive_item(FUNC_TICK, '0, '0);
		drive_item(FUNC_TICK, '0, '0);
		drive_item(FUNC_TICK, '0, '0);
		drive_item(FUNC_TICK, '0, '0);
		drive_item(FUNC_TICK, '0, '0);

		// limit of zero drops even with the server idle
		settle();
		write_limit('0);
		drive_item(FUNC_ARRIVAL, '1, '1);
		drive_item(FUNC_ARRIVAL, '0, '0);
		drive_item(FUNC_TICK, '0, '0);

		// limit of one: second waiting packet is dropped
		settle();
		write_limit(LEN_W'(1));
		drive_item(FUNC_ARRIVAL, TAG_W'(1), DUR_W'(1));
		drive_item(FUNC_ARRIVAL, TAG_W'(2), DUR_W'(1));
		drive_item(FUNC_ARRIVAL, TAG_W'(3), DUR_W'(1));
		drive_item(FUNC_TICK, '0, '0);
		drive_item(FUNC_TICK, '0, '0);
		drive_item(FUNC_TICK, '0, '0);

		// random phases
		run_phase(LEN_W'(64), 120, 50, 4, 1'b0);
		// limit above capacity, heavy arrivals fill all 64 entries
		run_phase(LEN_W'(127), 150, 85, 8, 1'b0);
		run_phase(LEN_W'(1), 80, 40, 3, 1'b0);
		// every arrival dropped, full-range payload
		run_phase('0, 40, 60, 0, 1'b1);
		run_phase(LEN_W'($urandom_range(2, 65)), 100, 55, 5, 1'b0);

		// closing phase without any idling
		settle();
		bursts_on = 1'b0;
		run_phase(LEN_W'(64), 80, 50, 3, 1'b0);

		settle();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.flag($sformatf("%0d outcomes never arrived", sb.pending()));
		end

		$display("run covered %0d item beats and %0d result checks over %0d limit writes",
			sb.n_items, sb.checked, n_writes);
		$display("packets served %0d, dropped %0d, mismatches %0d",
			sb.n_sent, sb.n_dropped, sb.errors);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
